// ===== rtl/jss_pkg.sv =====
// Package for the JTAG scan sequencer: microcode word, step addresses and control store.
package jss_pkg;

  localparam int unsigned CHUNK_BITS_DEF = 8;
  localparam int unsigned IDLE_MAX_DEF   = 63;
  localparam int unsigned RESET_TMS_CYCLES = 6;

  // Loop counter covers the largest idle count and the largest chunk.
  localparam int unsigned CNT_W  = 6;
  localparam int unsigned STEP_W = 4;
  localparam int unsigned FIELD_W = 8;

  typedef enum logic [1:0] {
    OP_RESET = 2'd0,
    OP_IR    = 2'd1,
    OP_DR    = 2'd2,
    OP_IDLE  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    TMS_ZERO,
    TMS_ONE,
    TMS_LAST_BIT
  } tms_sel_e;

  typedef enum logic [1:0] {
    END_NEVER,
    END_ALWAYS,
    END_IF_NOT_LAST
  } end_sel_e;

  typedef struct packed {
    tms_sel_e          tms_sel;
    logic              tdi_data;
    logic              status;
    logic              loop;
    logic              jump_dr;
    logic [STEP_W-1:0] target;
    end_sel_e          end_sel;
    logic              capture;
  } ctrl_t;

  localparam logic [STEP_W-1:0] ST_RESET_LOOP = 4'd0;
  localparam logic [STEP_W-1:0] ST_RESET_END  = 4'd1;
  localparam logic [STEP_W-1:0] ST_IDLE_LOOP  = 4'd2;
  localparam logic [STEP_W-1:0] ST_REJECT     = 4'd3;
  localparam logic [STEP_W-1:0] ST_SEL_DR     = 4'd4;
  localparam logic [STEP_W-1:0] ST_SEL_IR     = 4'd5;
  localparam logic [STEP_W-1:0] ST_CAPTURE    = 4'd6;
  localparam logic [STEP_W-1:0] ST_SHIFT      = 4'd7;
  localparam logic [STEP_W-1:0] ST_UPDATE     = 4'd8;
  localparam logic [STEP_W-1:0] ST_TO_IDLE    = 4'd9;

  // Control store: one word per TCK cycle kind.
  function automatic ctrl_t ucode(logic [STEP_W-1:0] step);
    ctrl_t w;
    w = '{tms_sel: TMS_ZERO, tdi_data: 1'b0, status: 1'b0, loop: 1'b0, jump_dr: 1'b0,
          target: '0, end_sel: END_NEVER, capture: 1'b0};
    case (step)
      ST_RESET_LOOP: begin
        w.tms_sel = TMS_ONE;
        w.loop    = 1'b1;
      end
      ST_RESET_END: begin
        w.end_sel = END_ALWAYS;
      end
      ST_IDLE_LOOP: begin
        w.loop    = 1'b1;
        w.end_sel = END_ALWAYS;
      end
      ST_REJECT: begin
        w.status  = 1'b1;
        w.end_sel = END_ALWAYS;
      end
      ST_SEL_DR: begin
        w.tms_sel = TMS_ONE;
        w.jump_dr = 1'b1;
        w.target  = ST_CAPTURE;
      end
      ST_SEL_IR: begin
        w.tms_sel = TMS_ONE;
      end
      ST_CAPTURE: begin
        w.tms_sel = TMS_ZERO;
      end
      ST_SHIFT: begin
        w.tms_sel  = TMS_LAST_BIT;
        w.tdi_data = 1'b1;
        w.loop     = 1'b1;
        w.end_sel  = END_IF_NOT_LAST;
        w.capture  = 1'b1;
      end
      ST_UPDATE: begin
        w.tms_sel = TMS_ONE;
      end
      ST_TO_IDLE: begin
        w.end_sel = END_ALWAYS;
        w.capture = 1'b1;
      end
      default: begin
        w.status  = 1'b1;
        w.end_sel = END_ALWAYS;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/jtag_scan_sequencer.sv =====
// JTAG scan sequencer: microcoded engine that turns commands into TCK cycle items.
// A command loads the step register before its first item is registered out.
// Throughput: one cycle item per clock within a command unless the output stalls. A
// reset gives TMS-high items then a low one, idle one per count, a chunk steps and bits.
// Ready returns at the edge that registers the last item of the previous command.
// Reset (rst_ni low) clears the engine, the open-scan state and the output valid flag.
module jtag_scan_sequencer
  import jss_pkg::*;
#(
  parameter int unsigned CHUNK_BITS = CHUNK_BITS_DEF,
  parameter int unsigned IDLE_MAX   = IDLE_MAX_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [7:0] tdi_bits, [11:8] bit_count, [19:12] tdo_levels, [25:20] idle_cycles, rest zero
  input  logic [31:0] s_axis_tdata_i,
  // [1:0] opcode
  input  logic [1:0]  s_axis_tuser_i,
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [0] tms_level, [1] tdi_level, [9:2] tdo_captured, rest zero
  output logic [15:0] m_axis_tdata_o,
  // [0] captured_valid, [1] status
  output logic [1:0]  m_axis_tuser_o,
  output logic        m_axis_tlast_o
);

  localparam logic [CNT_W-1:0] ChunkMax = CNT_W'(CHUNK_BITS);
  localparam logic [CNT_W-1:0] IdleMax  = CNT_W'(IDLE_MAX);
  localparam logic [CNT_W-1:0] ResetCnt = CNT_W'(RESET_TMS_CYCLES);

  logic               busy_q, busy_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [FIELD_W-1:0] sreg_q, sreg_d;
  logic [FIELD_W-1:0] cap_q, cap_d;
  logic               last_q, last_d;
  logic               scan_open_q, scan_open_d;
  logic               scan_ir_q, scan_ir_d;

  logic               m_valid_q, m_valid_d;
  logic               m_tms_q, m_tdi_q, m_capv_q, m_status_q, m_last_q;
  logic [FIELD_W-1:0] m_cap_q;

  logic               accept, advance, final_step, tms, at_one;
  ctrl_t              cw;

  opcode_e            op;
  logic [FIELD_W-1:0] in_tdi, in_tdo, tdo_mask;
  logic [3:0]         in_count;
  logic [5:0]         in_idle;
  logic [CNT_W-1:0]   count_sat, idle_sat;
  logic               is_ir, reject;

  assign s_axis_tready_o = !busy_q;
  assign accept  = s_axis_tvalid_i && !busy_q;
  assign advance = busy_q && (!m_valid_q || m_axis_tready_i);

  assign op       = opcode_e'(s_axis_tuser_i);
  assign in_tdi   = s_axis_tdata_i[7:0];
  assign in_count = s_axis_tdata_i[11:8];
  assign in_tdo   = s_axis_tdata_i[19:12];
  assign in_idle  = s_axis_tdata_i[25:20];
  assign is_ir    = (op == OP_IR);

  always_comb begin
    count_sat = (CNT_W'(in_count) > ChunkMax) ? ChunkMax : CNT_W'(in_count);
    idle_sat  = (CNT_W'(in_idle) > IdleMax) ? IdleMax : CNT_W'(in_idle);
    for (int i = 0; i < FIELD_W; i++) begin
      tdo_mask[i] = (CNT_W'(i) < count_sat);
    end
  end

  assign reject = scan_open_q &&
                  ((op == OP_IDLE) ||
                   (((op == OP_IR) || (op == OP_DR)) &&
                    ((count_sat == '0) || (is_ir != scan_ir_q))));

  assign cw     = ucode(step_q);
  assign at_one = (cnt_q == CNT_W'(1));

  always_comb begin
    case (cw.tms_sel)
      TMS_ONE:      tms = 1'b1;
      TMS_LAST_BIT: tms = last_q && at_one;
      default:      tms = 1'b0;
    endcase
  end

  always_comb begin
    final_step = 1'b0;
    if (!cw.loop || at_one) begin
      case (cw.end_sel)
        END_ALWAYS:      final_step = 1'b1;
        END_IF_NOT_LAST: final_step = !last_q;
        default:         final_step = 1'b0;
      endcase
    end
  end

  // Sequencer and command decode
  always_comb begin
    busy_d      = busy_q;
    step_d      = step_q;
    cnt_d       = cnt_q;
    sreg_d      = sreg_q;
    cap_d       = cap_q;
    last_d      = last_q;
    scan_open_d = scan_open_q;
    scan_ir_d   = scan_ir_q;

    if (accept) begin
      sreg_d = in_tdi;
      cap_d  = in_tdo & tdo_mask;
      last_d = s_axis_tlast_i;
      if (reject) begin
        busy_d = 1'b1;
        step_d = ST_REJECT;
      end else begin
        case (op)
          OP_RESET: begin
            busy_d      = 1'b1;
            step_d      = ST_RESET_LOOP;
            cnt_d       = ResetCnt;
            scan_open_d = 1'b0;
            scan_ir_d   = 1'b0;
          end
          OP_IDLE: begin
            busy_d = (idle_sat != '0);
            step_d = ST_IDLE_LOOP;
            cnt_d  = idle_sat;
          end
          default: begin
            // empty chunk outside a scan: drop silently
            if (count_sat != '0) begin
              busy_d      = 1'b1;
              step_d      = scan_open_q ? ST_SHIFT : ST_SEL_DR;
              cnt_d       = count_sat;
              scan_open_d = !s_axis_tlast_i;
              scan_ir_d   = is_ir;
            end
          end
        endcase
      end
    end else if (advance) begin
      if (cw.tdi_data) begin
        sreg_d = {1'b0, sreg_q[FIELD_W-1:1]};
      end
      if (final_step) begin
        busy_d = 1'b0;
      end else if (cw.loop && !at_one) begin
        cnt_d = cnt_q - CNT_W'(1);
      end else if (cw.jump_dr && !scan_ir_q) begin
        step_d = cw.target;
      end else begin
        step_d = step_q + STEP_W'(1);
      end
    end
  end

  assign m_valid_d = advance || (m_valid_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= ST_RESET_LOOP;
      cnt_q       <= '0;
      last_q      <= 1'b0;
      scan_open_q <= 1'b0;
      scan_ir_q   <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      step_q      <= step_d;
      cnt_q       <= cnt_d;
      last_q      <= last_d;
      scan_open_q <= scan_open_d;
      scan_ir_q   <= scan_ir_d;
      m_valid_q   <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sreg_q <= sreg_d;
    cap_q  <= cap_d;
    if (advance) begin
      m_tms_q    <= tms;
      m_tdi_q    <= cw.tdi_data && sreg_q[0];
      m_capv_q   <= cw.capture && final_step;
      m_cap_q    <= (cw.capture && final_step) ? cap_q : '0;
      m_status_q <= cw.status;
      m_last_q   <= final_step;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {6'b0, m_cap_q, m_tdi_q, m_tms_q};
  assign m_axis_tuser_o  = {m_status_q, m_capv_q};
  assign m_axis_tlast_o  = m_last_q;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking stream testbench for the JTAG scan sequencer with its own TCK cycle predictor.
module tb_top;
  import jss_pkg::*;

  localparam int unsigned RANDOM_ITEMS   = 200;
  localparam int unsigned LONG_HOLD_AT   = 400;
  localparam int unsigned LONG_HOLD      = 500;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES   = 20;

  typedef struct {
    opcode_e    op;
    logic [7:0] tdi;
    logic [3:0] count;
    logic       last;
    logic [7:0] tdo;
    logic [5:0] idle;
  } jtag_cmd_t;

  typedef struct {
    logic       tms;
    logic       tdi;
    logic [7:0] tdo;
    logic       cap_valid;
    logic       status;
    logic       last;
  } tck_cycle_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  // [7:0] tdi_bits, [11:8] bit_count, [19:12] tdo_levels, [25:20] idle_cycles, rest zero
  logic [31:0] s_axis_tdata_i  = '0;
  // [1:0] opcode
  logic [1:0]  s_axis_tuser_i  = '0;
  logic        s_axis_tlast_i  = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  // [0] tms_level, [1] tdi_level, [9:2] tdo_captured, rest zero
  logic [15:0] m_axis_tdata_o;
  // [0] captured_valid, [1] status
  logic [1:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  jtag_cmd_t   pending_cmds[$];
  tck_cycle_t  expected_cycles[$];
  jtag_cmd_t   cur_cmd;
  tck_cycle_t  seen_cycle;
  tck_cycle_t  want_cycle;
  logic        scan_open_q = 1'b0;
  logic        scan_ir_q   = 1'b0;
  bit          offering    = 1'b0;
  int unsigned send_wait   = 0;
  int unsigned hold_left   = 0;
  int unsigned cmds_total  = 0;
  int unsigned cmds_taken  = 0;
  int unsigned cycles_seen = 0;
  int unsigned rejects     = 0;
  int unsigned captures    = 0;
  int unsigned errors      = 0;
  int unsigned quiet_count = 0;

  jtag_scan_sequencer uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Every fourth stretch of 25 items runs without gaps.
  function automatic int unsigned draw_wait(int unsigned n);
    return ((n / 25) % 4 == 3) ? 0 : $urandom_range(0, 19);
  endfunction

  function automatic tck_cycle_t tck(logic tms, logic tdi);
    tck_cycle_t c;
    c.tms = tms;
    c.tdi = tdi;
    c.tdo = '0;
    c.cap_valid = 1'b0;
    c.status = 1'b0;
    c.last = 1'b0;
    return c;
  endfunction

  // Work out the expected TCK cycle items for a command and advance the TAP tracking state.
  function automatic void predict_cycles(jtag_cmd_t c);
    tck_cycle_t  run[$];
    tck_cycle_t  rej;
    int unsigned n;
    logic        is_ir;
    logic [7:0]  cap;
    is_ir = (c.op == OP_IR);
    cap = '0;
    rej = tck(1'b0, 1'b0);
    rej.status = 1'b1;
    case (c.op)
      OP_RESET: begin
        for (int i = 0; i < RESET_TMS_CYCLES; i++) run.push_back(tck(1'b1, 1'b0));
        run.push_back(tck(1'b0, 1'b0));
        scan_open_q = 1'b0;
        scan_ir_q = 1'b0;
      end
      OP_IDLE: begin
        n = (c.idle > IDLE_MAX_DEF) ? IDLE_MAX_DEF : c.idle;
        if (scan_open_q) run.push_back(rej);
        else for (int i = 0; i < n; i++) run.push_back(tck(1'b0, 1'b0));
      end
      default: begin
        n = (c.count > CHUNK_BITS_DEF) ? CHUNK_BITS_DEF : c.count;
        if (scan_open_q && (n == 0 || is_ir != scan_ir_q)) begin
          run.push_back(rej);
        end else if (n != 0) begin
          // Navigate from Run-Test/Idle to Shift on the first chunk of a scan.
          if (!scan_open_q) begin
            run.push_back(tck(1'b1, 1'b0));
            if (is_ir) run.push_back(tck(1'b1, 1'b0));
            run.push_back(tck(1'b0, 1'b0));
          end
          for (int i = 0; i < n; i++) begin
            run.push_back(tck(c.last && (i == n - 1), c.tdi[i]));
            cap[i] = c.tdo[i];
          end
          if (c.last) begin
            run.push_back(tck(1'b1, 1'b0));
            run.push_back(tck(1'b0, 1'b0));
          end
          run[run.size() - 1].tdo = cap;
          run[run.size() - 1].cap_valid = 1'b1;
          scan_open_q = !c.last;
          scan_ir_q = is_ir;
        end
      end
    endcase
    if (run.size() > 0) run[run.size() - 1].last = 1'b1;
    foreach (run[i]) expected_cycles.push_back(run[i]);
  endfunction

  task automatic add_cmd(opcode_e op, logic [7:0] tdi, logic [3:0] count, logic last,
                         logic [7:0] tdo, logic [5:0] idle);
    jtag_cmd_t c;
    c.op = op;
    c.tdi = tdi;
    c.count = count;
    c.last = last;
    c.tdo = tdo;
    c.idle = idle;
    pending_cmds.push_back(c);
  endtask

  // Random chunk content; now and then an oversized count.
  task automatic add_chunk(logic is_ir, logic last);
    logic [3:0] cnt;
    cnt = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(1, 8));
    add_cmd(is_ir ? OP_IR : OP_DR, 8'($urandom), cnt, last, 8'($urandom), 6'($urandom));
  endtask

  task automatic add_scan(logic is_ir, int unsigned chunks);
    for (int i = 0; i < chunks; i++) add_chunk(is_ir, i == chunks - 1);
  endtask

  task automatic fill_commands();
    int unsigned busy;
    int unsigned r;
    int unsigned k;
    logic        ir;
    // Directed part
    add_cmd(OP_RESET, 8'h00, 4'd0,  1'b0, 8'h00, 6'd0);
    add_cmd(OP_IDLE,  8'h00, 4'd0,  1'b0, 8'h00, 6'd0);
    add_cmd(OP_IDLE,  8'hFF, 4'd15, 1'b1, 8'hFF, 6'd63);
    add_cmd(OP_IDLE,  8'h00, 4'd0,  1'b0, 8'h00, 6'd1);
    add_cmd(OP_DR,    8'hFF, 4'd0,  1'b0, 8'hFF, 6'd0);
    add_cmd(OP_IR,    8'hFF, 4'd8,  1'b0, 8'h00, 6'd0);
    add_cmd(OP_IR,    8'h00, 4'd15, 1'b1, 8'hFF, 6'd63);
    add_cmd(OP_DR,    8'h01, 4'd1,  1'b1, 8'h01, 6'd0);
    add_cmd(OP_DR,    8'hA5, 4'd4,  1'b0, 8'h5A, 6'd0);
    add_cmd(OP_IR,    8'hFF, 4'd3,  1'b0, 8'hFF, 6'd0);
    add_cmd(OP_IDLE,  8'h00, 4'd0,  1'b0, 8'h00, 6'd5);
    add_cmd(OP_DR,    8'hFF, 4'd0,  1'b1, 8'hFF, 6'd0);
    add_cmd(OP_DR,    8'h3C, 4'd8,  1'b0, 8'hC3, 6'd0);
    add_cmd(OP_RESET, 8'h00, 4'd0,  1'b0, 8'h00, 6'd0);
    add_cmd(OP_DR,    8'h55, 4'd8,  1'b1, 8'hAA, 6'd0);
    add_cmd(OP_IR,    8'h96, 4'd9,  1'b0, 8'h69, 6'd0);
    add_cmd(OP_DR,    8'h03, 4'd2,  1'b1, 8'h03, 6'd0);
    add_cmd(OP_IR,    8'h01, 4'd1,  1'b1, 8'h00, 6'd0);
    add_cmd(OP_IDLE,  8'h00, 4'd0,  1'b0, 8'h00, 6'd32);
    add_cmd(OP_RESET, 8'hFF, 4'd15, 1'b1, 8'hFF, 6'd63);
    // Random part: mostly whole scans, some broken ones and plain noise
    busy = 0;
    while (busy < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      ir = 1'($urandom);
      if (r < 60) begin
        k = $urandom_range(1, 3);
        add_scan(ir, k);
        busy += k;
      end else if (r < 70) begin
        add_cmd(OP_IDLE, 8'($urandom), 4'($urandom), 1'($urandom), 8'($urandom),
                6'($urandom_range(1, 63)));
        busy++;
      end else if (r < 75) begin
        add_cmd(OP_RESET, 8'($urandom), 4'($urandom), 1'($urandom), 8'($urandom),
                6'($urandom));
        busy++;
      end else if (r < 90) begin
        // Open a scan, disturb it, then close it or abandon it by a reset
        add_chunk(ir, 1'b0);
        case ($urandom_range(0, 2))
          0: add_chunk(!ir, 1'($urandom));
          1: add_cmd(OP_IDLE, 8'h00, 4'd0, 1'b0, 8'h00, 6'($urandom));
          default: add_cmd(ir ? OP_IR : OP_DR, 8'($urandom), 4'd0, 1'($urandom),
                           8'($urandom), 6'($urandom));
        endcase
        if ($urandom_range(0, 3) == 0)
          add_cmd(OP_RESET, 8'h00, 4'd0, 1'b0, 8'h00, 6'd0);
        else
          add_chunk(ir, 1'b1);
        busy += 3;
      end else begin
        add_cmd(opcode_e'($urandom_range(0, 3)), 8'($urandom), 4'($urandom_range(0, 15)),
                1'($urandom), 8'($urandom), 6'($urandom));
        busy++;
      end
    end
    cmds_total = pending_cmds.size();
  endtask

  // Command source: hold each item until taken, then wait a drawn number of cycles.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      offering = 1'b0;
      send_wait = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        predict_cycles(cur_cmd);
        cmds_taken++;
        offering = 1'b0;
        send_wait = draw_wait(cmds_taken);
      end
      if (!offering) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (pending_cmds.size() > 0) begin
          cur_cmd = pending_cmds.pop_front();
          offering = 1'b1;
        end
      end
      s_axis_tvalid_i <= offering;
      s_axis_tdata_i  <= {6'b0, cur_cmd.idle, cur_cmd.tdo, cur_cmd.count, cur_cmd.tdi};
      s_axis_tuser_i  <= cur_cmd.op;
      s_axis_tlast_i  <= cur_cmd.last;
    end
  end

  task automatic check_field(string name, logic [7:0] want, logic [7:0] seen);
    if (want !== seen) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, seen);
    end
  endtask

  // Cycle sink: compare each item with the oldest prediction, stall at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      hold_left = 0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        seen_cycle.tms       = m_axis_tdata_o[0];
        seen_cycle.tdi       = m_axis_tdata_o[1];
        seen_cycle.tdo       = m_axis_tdata_o[9:2];
        seen_cycle.cap_valid = m_axis_tuser_o[0];
        seen_cycle.status    = m_axis_tuser_o[1];
        seen_cycle.last      = m_axis_tlast_o;
        if (expected_cycles.size() == 0) begin
          errors++;
          $display("%0t ns: unexpected cycle item, expected none, got tdata %0h tuser %0h",
                   $time, m_axis_tdata_o, m_axis_tuser_o);
        end else begin
          want_cycle = expected_cycles.pop_front();
          check_field("tms_level", want_cycle.tms, seen_cycle.tms);
          check_field("tdi_level", want_cycle.tdi, seen_cycle.tdi);
          check_field("tdo_captured", want_cycle.tdo, seen_cycle.tdo);
          check_field("captured_valid", want_cycle.cap_valid, seen_cycle.cap_valid);
          check_field("status", want_cycle.status, seen_cycle.status);
          check_field("last_of_run", want_cycle.last, seen_cycle.last);
        end
        cycles_seen++;
        if (seen_cycle.status) rejects++;
        if (seen_cycle.cap_valid) captures++;
        // Hold off once for a long stretch so that the engine backs up into its input
        hold_left = (cycles_seen == LONG_HOLD_AT) ? LONG_HOLD : draw_wait(cycles_seen);
      end else if (hold_left > 0) begin
        hold_left--;
      end
      m_axis_tready_i <= (hold_left == 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        quiet_count = 0;
      else
        quiet_count++;
      if (quiet_count >= WATCHDOG_LIMIT) begin
        $display("%0t ns: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("** jtag_scan_sequencer: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    fill_commands();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (!(cmds_taken == cmds_total && expected_cycles.size() == 0)) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_cycles.size() != 0) begin
      errors++;
      $display("%0t ns: %0d cycle items never arrived", $time, expected_cycles.size());
    end
    $display("Sent %0d commands and checked %0d TCK cycle items,", cmds_taken, cycles_seen);
    $display("of which %0d were rejections and %0d carried captured TDO.", rejects, captures);
    if (errors == 0) begin
      $display("** jtag_scan_sequencer: PASSED **");
    end else begin
      $display("** jtag_scan_sequencer: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/jss_pkg.sv
rtl/jtag_scan_sequencer.sv
tb/sv/tb_top.sv
